FILE: rtl/core/pohe_pkg.sv
package pohe_pkg;

    localparam int SampleBits  = 16;
    localparam int PhaseBits   = 16;
    localparam int CordicStages = 16;
    localparam int GuardBits   = 8;
    localparam int XyBits      = SampleBits + GuardBits + 3;
    localparam int CountBits   = 21;
    localparam logic [CountBits-1:0] CountLimit = 21'h100000;
    localparam logic [50:0] SqLimit = 51'h4000000000000;
    localparam logic [15:0] AmpReset = 16'd46341;
    localparam logic [31:0] CordicGain = 32'h9B74EDA8;

    localparam logic [1:0] CfgOffset    = 2'd0;
    localparam logic [1:0] CfgThreshold = 2'd1;
    localparam logic [1:0] CfgBitDepth  = 2'd2;

    typedef struct packed {
        logic signed [XyBits-1:0] x;
        logic signed [XyBits-1:0] y;
        logic [31:0]              z;
    } t_vec;

    typedef struct packed {
        t_vec        v;
        logic        valid;
        logic        last;
    } t_cell;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] t;
        case (i)
            0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
            3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
            6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
            9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
            12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
            15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
            18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
            21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

endpackage

FILE: rtl/core/phase_only_hologram_encoder.sv
// Phase-only hologram encoder. One sample enters per cycle when the output is
// not stalled; it passes the entry stage, 16 CORDIC cells and the amplitude,
// quantize, square and stats stages, which all advance together and hold
// while a result waits. The user must make configuration writes only while
// idle via i_cfg_we/i_cfg_index/i_cfg_data; the block does not enforce it.
module phase_only_hologram_encoder
    import pohe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_sample_real,
    input  logic signed [15:0] i_sample_imag,
    input  logic               i_frame_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_encoded_phase,
    output logic               o_phase_valid,
    output logic [15:0]        o_phase_error,
    output logic [20:0]        o_valid_total,
    output logic [20:0]        o_invalid_total,
    output logic [20:0]        o_rounded_total,
    output logic [15:0]        o_worst_error,
    output logic [15:0]        o_least_amplitude,
    output logic [15:0]        o_most_amplitude,
    output logic [50:0]        o_error_square_sum,
    output logic               o_frame_done
);

    logic [15:0] r_offset;
    logic [31:0] r_thresh;
    logic [4:0]  r_depth;
    logic        en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_thresh <= '0;
            r_depth  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgOffset:    r_offset <= i_cfg_data[15:0];
                CfgThreshold: r_thresh <= i_cfg_data;
                CfgBitDepth:  r_depth  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // entry stage: intensity compare, pre-rotation
    t_cell chain [CordicStages+1];
    t_cell r_in;
    logic  r_above [CordicStages+1];
    logic [32:0] inten;
    logic signed [XyBits-1:0] ex, ey;

    always_comb begin
        inten = {1'b0, 32'(i_sample_real * i_sample_real)}
              + {1'b0, 32'(i_sample_imag * i_sample_imag)};
        ex = XyBits'(i_sample_real);
        ey = XyBits'(i_sample_imag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid <= 1'b0;
        end else if (en) begin
            r_in.valid <= i_valid;
        end
        if (en) begin
            r_in.last <= i_frame_end;
            if (i_sample_real < 0) begin
                r_in.v.x <= (-ex) <<< GuardBits;
                r_in.v.y <= (-ey) <<< GuardBits;
                r_in.v.z <= 32'h80000000;
            end else begin
                r_in.v.x <= ex <<< GuardBits;
                r_in.v.y <= ey <<< GuardBits;
                r_in.v.z <= 32'd0;
            end
            r_above[0] <= inten > {1'b0, r_thresh};
        end
    end

    assign chain[0] = r_in;

    for (genvar g = 0; g < CordicStages; g++) begin : g_cell
        pohe_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_stage(5'(g)),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (en) r_above[g+1] <= r_above[g];
        end
    end

    t_cell end_cell;
    assign end_cell = chain[CordicStages];

    // stage A: amplitude multiply, desired phase
    logic        r_a_vld, r_a_last, r_a_above;
    logic [63:0] r_a_prod;
    logic [15:0] r_a_des;
    logic [15:0] des_raw;

    assign des_raw = 16'((end_cell.v.z + 32'h8000) >> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= end_cell.valid;
        end
        if (en) begin
            r_a_last  <= end_cell.last;
            r_a_above <= r_above[CordicStages];
            r_a_prod  <= 64'($unsigned(32'(end_cell.v.x))) * {32'd0, CordicGain};
            r_a_des   <= (r_above[CordicStages] ? des_raw : 16'd0) + r_offset;
        end
    end

    // stage B: amplitude round, quantize, error
    logic        r_b_vld, r_b_last, r_b_above;
    logic [15:0] r_b_amp, r_b_enc, r_b_err;
    logic [24:0] amp_w;
    logic [15:0] enc, dd, err;
    logic [4:0]  sh;
    logic [16:0] rnd;

    always_comb begin
        amp_w = 25'((r_a_prod + 64'h8000000000) >> 40);
        sh    = 5'(PhaseBits) - r_depth;
        rnd   = {1'b0, r_a_des} + (17'd1 << (sh - 5'd1));
        if (r_depth == 5'd0 || r_depth >= 5'(PhaseBits)) begin
            enc = r_a_des;
        end else begin
            enc = 16'((rnd >> sh) << sh);
        end
        dd  = enc - r_a_des;
        err = dd <= 16'h8000 ? dd : 16'(17'h10000 - {1'b0, dd});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
        if (en) begin
            r_b_last  <= r_a_last;
            r_b_above <= r_a_above;
            r_b_amp   <= amp_w > 25'hFFFF ? 16'hFFFF : amp_w[15:0];
            r_b_enc   <= enc;
            r_b_err   <= r_a_above ? err : 16'd0;
        end
    end

    // stage C: square
    logic        r_c_vld, r_c_last, r_c_above;
    logic [15:0] r_c_amp, r_c_enc, r_c_err;
    logic [31:0] r_c_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
        if (en) begin
            r_c_last  <= r_b_last;
            r_c_above <= r_b_above;
            r_c_amp   <= r_b_amp;
            r_c_enc   <= r_b_enc;
            r_c_err   <= r_b_err;
            r_c_sq    <= 32'(r_b_err * r_b_err);
        end
    end

    // stage D: statistics and output register
    logic [20:0] r_vcnt, r_icnt, r_rcnt;
    logic [15:0] r_worst, r_least, r_most;
    logic [50:0] r_sq;
    logic [20:0] n_vcnt, n_icnt, n_rcnt;
    logic [15:0] n_worst, n_least, n_most;
    logic [50:0] n_sq;
    logic [51:0] sq_sum;

    always_comb begin
        n_vcnt  = r_vcnt;
        n_icnt  = r_icnt;
        n_rcnt  = r_rcnt;
        n_worst = r_worst;
        n_sq    = r_sq;
        n_least = r_c_amp < r_least ? r_c_amp : r_least;
        n_most  = r_c_amp > r_most ? r_c_amp : r_most;
        sq_sum  = {1'b0, r_sq} + {20'd0, r_c_sq};
        if (r_c_above) begin
            if (r_vcnt < CountLimit) n_vcnt = r_vcnt + 21'd1;
            if (r_c_err != 16'd0 && r_rcnt < CountLimit) n_rcnt = r_rcnt + 21'd1;
            if (r_c_err > r_worst) n_worst = r_c_err;
            n_sq = sq_sum > {1'b0, SqLimit} ? SqLimit : sq_sum[50:0];
        end else if (r_icnt < CountLimit) begin
            n_icnt = r_icnt + 21'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_vcnt  <= '0;
            r_icnt  <= '0;
            r_rcnt  <= '0;
            r_worst <= '0;
            r_least <= AmpReset;
            r_most  <= '0;
            r_sq    <= '0;
        end else if (en) begin
            o_valid <= r_c_vld;
            if (r_c_vld) begin
                if (r_c_last) begin
                    r_vcnt  <= '0;
                    r_icnt  <= '0;
                    r_rcnt  <= '0;
                    r_worst <= '0;
                    r_least <= AmpReset;
                    r_most  <= '0;
                    r_sq    <= '0;
                end else begin
                    r_vcnt  <= n_vcnt;
                    r_icnt  <= n_icnt;
                    r_rcnt  <= n_rcnt;
                    r_worst <= n_worst;
                    r_least <= n_least;
                    r_most  <= n_most;
                    r_sq    <= n_sq;
                end
            end
        end
        if (en && r_c_vld) begin
            o_encoded_phase    <= r_c_enc;
            o_phase_valid      <= r_c_above;
            o_phase_error      <= r_c_err;
            o_valid_total      <= n_vcnt;
            o_invalid_total    <= n_icnt;
            o_rounded_total    <= n_rcnt;
            o_worst_error      <= n_worst;
            o_least_amplitude  <= n_least;
            o_most_amplitude   <= n_most;
            o_error_square_sum <= n_sq;
            o_frame_done       <= r_c_last;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_phase_valid |-> o_phase_error == 16'd0)
        else $error("error on invalid beat");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_phase_error <= 16'h8000)
        else $error("error beyond half turn");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_encoded_phase))
        else $error("result dropped under stall");

endmodule

FILE: rtl/core/pohe_cell.sv
module pohe_cell
    import pohe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [4:0] i_stage,
    input  t_cell      i_cell,
    output t_cell      o_cell
);

    t_cell r_cell;
    t_cell n_cell;

    always_comb begin
        n_cell = i_cell;
        if (i_cell.v.y >= 0) begin
            n_cell.v.x = i_cell.v.x + (i_cell.v.y >>> i_stage);
            n_cell.v.y = i_cell.v.y - (i_cell.v.x >>> i_stage);
            n_cell.v.z = i_cell.v.z + atan_turn(int'(i_stage));
        end else begin
            n_cell.v.x = i_cell.v.x - (i_cell.v.y >>> i_stage);
            n_cell.v.y = i_cell.v.y + (i_cell.v.x >>> i_stage);
            n_cell.v.z = i_cell.v.z - atan_turn(int'(i_stage));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell.valid <= i_cell.valid;
        end
        if (i_en) begin
            r_cell.v    <= n_cell.v;
            r_cell.last <= i_cell.last;
        end
    end

    assign o_cell = r_cell;

endmodule

FILE: tb/tb_phase_only_hologram_encoder.sv
module tb_phase_only_hologram_encoder;
    import pohe_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] code;
        logic        ok;
        logic [15:0] err;
        logic [20:0] nvalid;
        logic [20:0] ninvalid;
        logic [20:0] nrounded;
        logic [15:0] worst;
        logic [15:0] amp_lo;
        logic [15:0] amp_hi;
        logic [50:0] sqsum;
        logic        done;
    } t_phase_out;

    typedef struct {
        logic [15:0] re;
        logic [15:0] im;
        logic        last;
        logic [15:0] code;
        logic        has_code;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CfgOffset;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [15:0] i_sample_real = '0;
    logic signed [15:0] i_sample_imag = '0;
    logic i_frame_end = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [15:0] o_encoded_phase;
    logic o_phase_valid;
    logic [15:0] o_phase_error;
    logic [20:0] o_valid_total;
    logic [20:0] o_invalid_total;
    logic [20:0] o_rounded_total;
    logic [15:0] o_worst_error;
    logic [15:0] o_least_amplitude;
    logic [15:0] o_most_amplitude;
    logic [50:0] o_error_square_sum;
    logic o_frame_done;

    phase_only_hologram_encoder uut (.*);

    always #5 i_clk = ~i_clk;

    logic [15:0] offset_reg;
    logic [31:0] thresh_reg;
    logic [4:0]  depth_reg;
    logic [63:0] cnt_valid, cnt_invalid, cnt_rounded;
    logic [63:0] worst_reg, amp_lo_reg, amp_hi_reg, sq_acc;
    t_phase_out  pending_phases[$];
    int          mismatches = 0;
    bit          calm = 0;

    function automatic logic [31:0] atan_step(int i);
        case (i)
            0: return 32'd536870912;  1: return 32'd316933406;  2: return 32'd167458907;
            3: return 32'd85004756;   4: return 32'd42667331;   5: return 32'd21354465;
            6: return 32'd10679838;   7: return 32'd5340245;    8: return 32'd2670163;
            9: return 32'd1335087;    10: return 32'd667544;    11: return 32'd333772;
            12: return 32'd166886;    13: return 32'd83443;     14: return 32'd41722;
            default: return 32'd20861;
        endcase
    endfunction

    function automatic logic [15:0] round_phase(logic [15:0] ph);
        int s;
        logic [16:0] t;
        if (depth_reg == 0 || depth_reg >= 16) return ph;
        s = 16 - depth_reg;
        t = ({1'b0, ph} + (17'd1 << (s - 1))) >> s;
        t = t & ((17'd1 << depth_reg) - 1);
        return 16'(t << s);
    endfunction

    function automatic void clear_frame();
        cnt_valid = 0; cnt_invalid = 0; cnt_rounded = 0;
        worst_reg = 0; amp_lo_reg = 46341; amp_hi_reg = 0; sq_acc = 0;
    endfunction

    function automatic t_phase_out encode_sample(logic [15:0] re_b, logic [15:0] im_b,
                                                 logic last);
        longint re, im, x, y, dx, dy;
        logic [63:0] power, amp, d, e;
        logic [31:0] z;
        logic [15:0] want;
        t_phase_out r;
        re = longint'($signed(re_b));
        im = longint'($signed(im_b));
        power = 64'(re * re) + 64'(im * im);
        x = re; y = im; z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        x = x * 256; y = y * 256;
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i; dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        amp = (64'(x) * 64'h9B74EDA8 + (64'd1 << 39)) >> 40;
        if (amp > 64'hFFFF) amp = 64'hFFFF;
        if (amp < amp_lo_reg) amp_lo_reg = amp;
        if (amp > amp_hi_reg) amp_hi_reg = amp;
        e = 0;
        r.ok = power > {32'd0, thresh_reg};
        if (!r.ok) begin
            r.code = round_phase(offset_reg);
            if (cnt_invalid < 64'h100000) cnt_invalid++;
        end else begin
            want = 16'((({32'd0, z} + 64'h8000) >> 16)) + offset_reg;
            r.code = round_phase(want);
            d = 64'(16'(r.code - want));
            e = d <= 32768 ? d : 65536 - d;
            if (cnt_valid < 64'h100000) cnt_valid++;
            if (e != 0 && cnt_rounded < 64'h100000) cnt_rounded++;
            if (e > worst_reg) worst_reg = e;
            sq_acc += e * e;
            if (sq_acc > (64'd1 << 50)) sq_acc = 64'd1 << 50;
        end
        r.err = e[15:0];
        r.nvalid = cnt_valid[20:0];
        r.ninvalid = cnt_invalid[20:0];
        r.nrounded = cnt_rounded[20:0];
        r.worst = worst_reg[15:0];
        r.amp_lo = amp_lo_reg[15:0];
        r.amp_hi = amp_hi_reg[15:0];
        r.sqsum = sq_acc[50:0];
        r.done = last;
        if (last) clear_frame();
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CfgOffset: offset_reg = val[15:0];
            CfgThreshold: thresh_reg = val;
            default: depth_reg = val[4:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_beat(logic [15:0] re, logic [15:0] im, logic last);
        while (!calm && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_real <= re;
        i_sample_imag <= im;
        i_frame_end <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_phases.push_back(encode_sample(re, im, last));
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_phases.size() != 0) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_part();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n)
            i_ready <= calm || ($urandom_range(99) >= 31);
    end

    always @(posedge i_clk) begin
        t_phase_out w;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_phases.size() == 0) begin
                report_mismatch("unexpected beat", 0, 0);
            end else begin
                w = pending_phases.pop_front();
                if (o_encoded_phase !== w.code) report_mismatch("encoded_phase", o_encoded_phase, w.code);
                if (o_phase_valid !== w.ok) report_mismatch("phase_valid", o_phase_valid, w.ok);
                if (o_phase_error !== w.err) report_mismatch("phase_error", o_phase_error, w.err);
                if (o_valid_total !== w.nvalid) report_mismatch("valid_total", o_valid_total, w.nvalid);
                if (o_invalid_total !== w.ninvalid)
                    report_mismatch("invalid_total", o_invalid_total, w.ninvalid);
                if (o_rounded_total !== w.nrounded)
                    report_mismatch("rounded_total", o_rounded_total, w.nrounded);
                if (o_worst_error !== w.worst) report_mismatch("worst_error", o_worst_error, w.worst);
                if (o_least_amplitude !== w.amp_lo)
                    report_mismatch("least_amplitude", o_least_amplitude, w.amp_lo);
                if (o_most_amplitude !== w.amp_hi)
                    report_mismatch("most_amplitude", o_most_amplitude, w.amp_hi);
                if (o_error_square_sum !== w.sqsum)
                    report_mismatch("error_square_sum", o_error_square_sum, w.sqsum);
                if (o_frame_done !== w.done) report_mismatch("frame_done", o_frame_done, w.done);
            end
        end
    end

    initial begin
        t_row rows[$];
        t_phase_out w;
        logic [4:0] depths[6];
        depths = '{5'd0, 5'd16, 5'd1, 5'd8, 5'd15, 5'd31};
        offset_reg = 0; thresh_reg = 0; depth_reg = 0;
        clear_frame();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sample is invalid at reset with offset 0; extremes follow
        rows.push_back('{16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b1});
        rows.push_back('{16'h7FFF, 16'h0000, 1'b0, 16'h0000, 1'b1});
        rows.push_back('{16'h8000, 16'h0000, 1'b0, 16'h8000, 1'b1});
        rows.push_back('{16'h0000, 16'h7FFF, 1'b0, 16'h4000, 1'b1});
        rows.push_back('{16'h0000, 16'h8000, 1'b0, 16'hC000, 1'b1});
        rows.push_back('{16'h8000, 16'h8000, 1'b0, 16'h0, 1'b0});
        rows.push_back('{16'h7FFF, 16'h7FFF, 1'b0, 16'h0, 1'b0});
        rows.push_back('{16'h8000, 16'h7FFF, 1'b0, 16'h0, 1'b0});
        rows.push_back('{16'hFFFF, 16'h0001, 1'b0, 16'h0, 1'b0});
        rows.push_back('{16'hFFFF, 16'hFFFF, 1'b0, 16'h0, 1'b0});
        rows.push_back('{16'h0001, 16'hFFFF, 1'b1, 16'h0, 1'b0});
        rows.push_back('{16'h1234, 16'hEDCB, 1'b1, 16'h0, 1'b0});
        foreach (rows[k]) begin
            if (rows[k].has_code) begin
                w = encode_sample(rows[k].re, rows[k].im, rows[k].last);
                if (w.code !== rows[k].code) report_mismatch("table row", w.code, rows[k].code);
            end
        end
        clear_frame();
        foreach (rows[k]) send_beat(rows[k].re, rows[k].im, rows[k].last);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CfgOffset, ph == 1 ? 32'hFFFF : (ph == 2 ? 32'd0 : $urandom));
            write_reg(CfgThreshold, ph == 3 ? 32'h8000_0000 : (ph == 4 ? 32'hFFFF_FFFF :
                      (ph == 5 ? 32'd0 : $urandom_range(32'h4000_0000))));
            write_reg(CfgBitDepth, ph < 6 ? depths[ph] : $urandom_range(31));
            calm = (ph == 7);
            for (int n = 0; n < 125; n++)
                send_beat(rand_part(), rand_part(), $urandom_range(15) == 0);
            send_beat(rand_part(), rand_part(), 1'b1);
            drain();
        end
        calm = 0;

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
